// File: hw/rtl/lpl_pkg.sv
// Package: shared types, constants and register indexes for the peak limiter
package lpl_pkg;
	localparam int SampleBits = 24;
	localparam int DelayDepth = 2048;
	localparam int AddrBits = $clog2(DelayDepth);
	localparam logic [16:0] Unity = 17'h10000;

	localparam logic [2:0] RegThreshold = 3'd0;
	localparam logic [2:0] RegAttack    = 3'd1;
	localparam logic [2:0] RegRelease   = 3'd2;
	localparam logic [2:0] RegDelay     = 3'd3;
	localparam logic [2:0] RegMix       = 3'd4;
	localparam logic [2:0] RegGain      = 3'd5;
	localparam logic [2:0] RegBypass    = 3'd6;

	typedef struct packed {
		logic signed [SampleBits-1:0] left_in;
		logic signed [SampleBits-1:0] right_in;
	} frame_in_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] left_out;
		logic signed [SampleBits-1:0] right_out;
		logic [16:0]                  gain_now;
	} frame_out_t;

	typedef struct packed {
		logic [16:0] threshold_level;
		logic [16:0] attack_step;
		logic [16:0] release_step;
		logic [10:0] lookahead_delay;
		logic [16:0] wet_mix;
		logic [18:0] wet_gain;
		logic        bypass;
	} cfg_t;

	// front to back: the frame with its peak
	typedef struct packed {
		logic signed [SampleBits-1:0] l;
		logic signed [SampleBits-1:0] r;
		logic [SampleBits-1:0]        peak;
	} job_t;
endpackage

// File: hw/rtl/lpl_front.sv
// Front end: accepts frames, takes the linked peak, queues jobs for the back end
module lpl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lpl_pkg::frame_in_t in_data,
	output logic              in_stall,
	output logic              q_valid,
	output lpl_pkg::job_t     q_data,
	input  logic              q_pop
);
	import lpl_pkg::*;

	job_t q_mem_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic [SampleBits-1:0] ml, mr;
	job_t nj;
	logic push;

	always_comb begin
		ml = in_data.left_in[SampleBits-1] ? SampleBits'(-in_data.left_in) : in_data.left_in;
		mr = in_data.right_in[SampleBits-1] ? SampleBits'(-in_data.right_in) : in_data.right_in;
		nj.l = in_data.left_in;
		nj.r = in_data.right_in;
		nj.peak = (mr > ml) ? mr : ml;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// File: hw/rtl/lpl_back.sv
// Back end: divider, envelope, delay line and mixing sequencer
module lpl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lpl_pkg::cfg_t      cfg,
	input  logic               q_valid,
	input  lpl_pkg::job_t      q_data,
	output logic               q_pop,
	output logic               out_valid,
	output lpl_pkg::frame_out_t out_data,
	input  logic               out_stall,
	output logic               busy
);
	import lpl_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001, S_DIV  = 8'b00000010, S_ENV1 = 8'b00000100,
		S_ENV2 = 8'b00001000, S_RD   = 8'b00010000, S_MUL  = 8'b00100000,
		S_SUM  = 8'b01000000, S_OUT  = 8'b10000000
	} state_t;

	localparam int DivW = 17 + SampleBits - 1;

	state_t st_q;
	job_t job_q;
	logic [16:0] env_q, target_q;
	logic [AddrBits-1:0] wp_q, rd_addr_q;
	// frames written so far, saturating; unwritten taps read as zero
	logic [AddrBits-1:0] fill_q;
	logic tap_ok_q;
	logic [5:0] cnt_q;
	logic [DivW-1:0] quo_q;
	logic [SampleBits:0] rem_q;
	logic signed [SampleBits-1:0] lmem [DelayDepth];
	logic signed [SampleBits-1:0] rmem [DelayDepth];
	logic signed [SampleBits-1:0] dl_q, dr_q;
	// multiply sequence: per channel wet chain then dry
	logic [2:0] mstep_q;
	logic ch_q;
	logic signed [SampleBits+3:0] w_q;
	logic signed [SampleBits+3:0] dry_q;
	logic signed [SampleBits-1:0] lo_q, ro_q;
	frame_out_t out_q;
	logic out_v_q;
	logic [17:0] mv_q;

	logic [16:0] mix_c, a_step, r_step, step;
	logic [AddrBits-1:0] dly;
	logic [DivW-1:0] thr;
	logic [DivW+16:0] peak_sh, thr_sh;
	logic [SampleBits:0] rem_sh;
	logic [16:0] d_mag;
	logic [33:0] mvp;
	logic signed [SampleBits+3:0] ma;
	logic signed [19:0] mb;
	logic signed [SampleBits+24:0] prod, prod_r;
	logic [SampleBits+24:0] pm;
	logic signed [SampleBits+3:0] rp;
	logic signed [SampleBits+4:0] tot;
	logic signed [SampleBits-1:0] sat;

	always_comb begin
		mix_c = (cfg.wet_mix > Unity) ? Unity : cfg.wet_mix;
		a_step = (cfg.attack_step > Unity) ? Unity : cfg.attack_step;
		r_step = (cfg.release_step > Unity) ? Unity : cfg.release_step;
		dly = (cfg.lookahead_delay > 11'(DelayDepth-1)) ?
			AddrBits'(DelayDepth-1) : AddrBits'(cfg.lookahead_delay);
		step = (target_q < env_q) ? a_step : r_step;
		d_mag = (target_q < env_q) ? env_q - target_q : target_q - env_q;
		mvp = 34'(step) * 34'(d_mag) + 34'd65535;
		thr = {cfg.threshold_level, {(SampleBits-1){1'b0}}};
		peak_sh = {17'b0, job_q.peak, 16'b0};
		thr_sh = {17'b0, thr};
		rem_sh = {rem_q[SampleBits-1:0], quo_q[DivW-1]};
		// multiplier operands
		case (mstep_q)
			3'd0: begin ma = ch_q ? SampleBits'(dr_q) : SampleBits'(dl_q); mb = 20'(env_q); end
			3'd1: begin ma = w_q; mb = 20'(mix_c); end
			3'd2: begin ma = w_q; mb = 20'(cfg.wet_gain); end
			default: begin
				ma = ch_q ? (SampleBits+4)'(job_q.r) : (SampleBits+4)'(job_q.l);
				mb = 20'(Unity - mix_c);
			end
		endcase
		prod = (SampleBits+25)'(ma) * (SampleBits+25)'(mb);
		pm = prod[SampleBits+24] ? -prod : prod;
		prod_r = (SampleBits+25)'((pm + 32768) >> 16);
		rp = prod[SampleBits+24] ? -(SampleBits+4)'(prod_r) : (SampleBits+4)'(prod_r);
		tot = (SampleBits+5)'(dry_q) + (SampleBits+5)'(w_q);
		if (tot > (SampleBits+5)'(2**(SampleBits-1)-1)) sat = {1'b0, {(SampleBits-1){1'b1}}};
		else if (tot < -(SampleBits+5)'(2**(SampleBits-1))) sat = {1'b1, {(SampleBits-1){1'b0}}};
		else sat = tot[SampleBits-1:0];
	end

	assign q_pop = (st_q == S_IDLE) && q_valid && !out_v_q;
	assign out_valid = out_v_q;
	assign out_data = out_q;
	assign busy = (st_q != S_IDLE) || out_v_q;

	always_ff @(posedge clk) begin
		if (st_q == S_RD) begin
			lmem[wp_q] <= job_q.l;
			rmem[wp_q] <= job_q.r;
		end
		if (st_q == S_MUL && mstep_q == 3'd7) begin
			dl_q <= !tap_ok_q ? '0 : (rd_addr_q == wp_q) ? job_q.l : lmem[rd_addr_q];
			dr_q <= !tap_ok_q ? '0 : (rd_addr_q == wp_q) ? job_q.r : rmem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			env_q <= Unity;
			wp_q <= '0;
			fill_q <= '0;
			out_v_q <= 1'b0;
			cnt_q <= '0;
			mstep_q <= '0;
			ch_q <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			case (st_q)
				S_IDLE: if (q_pop) begin
					job_q <= q_data;
					if (cfg.bypass) begin
						out_q.left_out <= q_data.l;
						out_q.right_out <= q_data.r;
						out_q.gain_now <= env_q;
						out_v_q <= 1'b1;
					end else begin
						st_q <= S_DIV;
						quo_q <= thr;
						rem_q <= '0;
						cnt_q <= '0;
						target_q <= Unity;
					end
				end
				S_DIV: begin
					if (cnt_q == 6'(DivW)) begin
						if (peak_sh > thr_sh && job_q.peak != '0) target_q <= quo_q[16:0];
						st_q <= S_ENV1;
					end else begin
						cnt_q <= cnt_q + 6'd1;
						if (rem_sh >= {1'b0, job_q.peak}) begin
							rem_q <= rem_sh - {1'b0, job_q.peak};
							quo_q <= {quo_q[DivW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[DivW-2:0], 1'b0};
						end
					end
				end
				S_ENV1: begin
					mv_q <= mvp[33:16];
					st_q <= S_ENV2;
				end
				S_ENV2: begin
					if (target_q < env_q) env_q <= env_q - 17'(mv_q);
					else if (18'(env_q) + mv_q > 18'(Unity)) env_q <= Unity;
					else env_q <= 17'(18'(env_q) + mv_q);
					rd_addr_q <= wp_q - dly;
					tap_ok_q <= (dly <= fill_q);
					st_q <= S_MUL;
					mstep_q <= 3'd7;
					ch_q <= 1'b0;
				end
				S_MUL: begin
					// step 7 fetches the delayed pair, then 0..3 per channel
					if (mstep_q == 3'd7) mstep_q <= 3'd0;
					else if (mstep_q == 3'd3) begin
						dry_q <= rp;
						st_q <= S_SUM;
					end else begin
						w_q <= rp;
						mstep_q <= mstep_q + 3'd1;
					end
				end
				S_SUM: begin
					if (!ch_q) begin
						lo_q <= sat;
						ch_q <= 1'b1;
						mstep_q <= 3'd0;
						st_q <= S_MUL;
					end else begin
						ro_q <= sat;
						st_q <= S_RD;
					end
				end
				S_RD: st_q <= S_OUT;
				S_OUT: if (!out_v_q) begin
					out_q.left_out <= lo_q;
					out_q.right_out <= ro_q;
					out_q.gain_now <= env_q;
					out_v_q <= 1'b1;
					wp_q <= wp_q + 1'b1;
					if (fill_q != '1) fill_q <= fill_q + 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/lookahead_peak_limiter.sv
// Top level: stereo-linked lookahead peak limiter
// A limited frame holds the back end through the pop, a 40-step restoring divider for the
// threshold/peak target plus a finishing step, two envelope states, a delay line fetch, four
// steps on one shared multiplier and a saturation step per channel, delay line write, output,
// and the clearing of the output; output stalls lengthen it. Bypassed frames are registered
// straight from the pop to the output. A two-entry queue holds frames taken by the front
// while the back end works.
// Configuration writes are accepted only while the queue and the back end are empty.
module lookahead_peak_limiter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lpl_pkg::frame_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lpl_pkg::frame_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [18:0]         cfg_data
);
	import lpl_pkg::*;

	cfg_t cfg_q;
	logic q_valid, q_pop, busy;
	job_t q_data;

	assign cfg_ready = !busy && !q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_level <= 17'd65536;
			cfg_q.attack_step <= 17'd65536;
			cfg_q.release_step <= 17'd6554;
			cfg_q.lookahead_delay <= '0;
			cfg_q.wet_mix <= 17'd65536;
			cfg_q.wet_gain <= 19'd65536;
			cfg_q.bypass <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegThreshold: cfg_q.threshold_level <= cfg_data[16:0];
				RegAttack:    cfg_q.attack_step <= cfg_data[16:0];
				RegRelease:   cfg_q.release_step <= cfg_data[16:0];
				RegDelay:     cfg_q.lookahead_delay <= cfg_data[10:0];
				RegMix:       cfg_q.wet_mix <= cfg_data[16:0];
				RegGain:      cfg_q.wet_gain <= cfg_data;
				RegBypass:    cfg_q.bypass <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lpl_front u_front (
		.clk, .arst_n, .in_valid, .in_data, .in_stall,
		.q_valid, .q_data, .q_pop
	);

	lpl_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .q_data, .q_pop,
		.out_valid, .out_data, .out_stall, .busy
	);

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_gain_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.gain_now <= Unity)
		else $error("gain above unity");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !out_valid)
		else $error("new job while result pending");
endmodule
